// ----- design/blms_pkg.sv -----
// Shared types and constants for the bicolor LED matrix scanner.
`default_nettype none

package blms_pkg;

  // Show parts
  localparam logic [1:0] PART_STATIC    = 2'd0;
  localparam logic [1:0] PART_FLASH_ON  = 2'd1;
  localparam logic [1:0] PART_FLASH_OFF = 2'd2;
  localparam logic [1:0] PART_ROTATE    = 2'd3;

  // Request types
  localparam logic REQ_TICK  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_STATIC_REFRESHES    = 3'd0;
  localparam logic [2:0] REG_FLASH_ON_REFRESHES  = 3'd1;
  localparam logic [2:0] REG_FLASH_OFF_REFRESHES = 3'd2;
  localparam logic [2:0] REG_ROTATE_REFRESHES    = 3'd3;
  localparam logic [2:0] REG_PLAY_ASCENDING      = 3'd4;

  // Register reset values
  localparam logic [15:0] STATIC_RESET    = 16'd150;
  localparam logic [15:0] FLASH_ON_RESET  = 16'd100;
  localparam logic [15:0] FLASH_OFF_RESET = 16'd100;
  localparam logic [15:0] ROTATE_RESET    = 16'd200;
  localparam logic        FORWARD_RESET   = 1'b1;

  // Display words
  localparam logic [7:0]  TOP_ROW_BIT = 8'h80;
  localparam logic [7:0]  ALL_OFF     = 8'hFF;
  localparam logic [15:0] WORD_OFF    = 16'hFFFF;

  // Configuration register file contents
  typedef struct packed {
    logic [15:0] static_refreshes;
    logic [15:0] flash_on_refreshes;
    logic [15:0] flash_off_refreshes;
    logic [15:0] rotate_refreshes;
    logic        play_ascending;
  } cfg_t;

  // Per-tick display info from the sequencer
  typedef struct packed {
    logic [7:0] row_drive;
    logic [1:0] show_part;
    logic [1:0] frame_shown;
  } tick_info_t;

endpackage

`default_nettype wire

// ----- design/blms_cfg.sv -----
// APB register file holding the show timing and rotation direction.
`default_nettype none

module blms_cfg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          psel,
  input  wire logic          penable,
  input  wire logic          pwrite,
  input  wire logic [4:0]    paddr,
  input  wire logic [31:0]   pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output blms_pkg::cfg_t     cfg
);
  import blms_pkg::*;

  logic       wr_en;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[4:2];

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.static_refreshes    <= STATIC_RESET;
      cfg.flash_on_refreshes  <= FLASH_ON_RESET;
      cfg.flash_off_refreshes <= FLASH_OFF_RESET;
      cfg.rotate_refreshes    <= ROTATE_RESET;
      cfg.play_ascending      <= FORWARD_RESET;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_STATIC_REFRESHES:    cfg.static_refreshes    <= pwdata[15:0];
        REG_FLASH_ON_REFRESHES:  cfg.flash_on_refreshes  <= pwdata[15:0];
        REG_FLASH_OFF_REFRESHES: cfg.flash_off_refreshes <= pwdata[15:0];
        REG_ROTATE_REFRESHES:    cfg.rotate_refreshes    <= pwdata[15:0];
        REG_PLAY_ASCENDING:      cfg.play_ascending      <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (reg_idx)
      REG_STATIC_REFRESHES:    prdata = {16'd0, cfg.static_refreshes};
      REG_FLASH_ON_REFRESHES:  prdata = {16'd0, cfg.flash_on_refreshes};
      REG_FLASH_OFF_REFRESHES: prdata = {16'd0, cfg.flash_off_refreshes};
      REG_ROTATE_REFRESHES:    prdata = {16'd0, cfg.rotate_refreshes};
      REG_PLAY_ASCENDING:      prdata = {31'd0, cfg.play_ascending};
      default:                 prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// ----- design/blms_seq.sv -----
// Show sequencer: row walk, refresh counting, part and frame stepping.
`default_nettype none

module blms_seq #(
  parameter int ROWS   = 8,
  parameter int FRAMES = 4,
  parameter int RW     = 3,
  parameter int FW     = 2,
  parameter int AW     = 6
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            advance,
  input  wire blms_pkg::cfg_t  cfg,
  output logic [AW-1:0]        rd_addr,
  output blms_pkg::tick_info_t info
);
  import blms_pkg::*;

  localparam logic [RW-1:0] LAST_ROW   = RW'(ROWS - 1);
  localparam logic [FW-1:0] LAST_FRAME = FW'(FRAMES - 1);

  logic [RW-1:0] row_position, row_position_next;
  logic [15:0]   refresh_count, refresh_count_next;
  logic [1:0]    part_now, part_now_next;
  logic [FW-1:0] frame_now, frame_now_next;

  logic [15:0]   limit_raw, limit;
  logic [15:0]   refresh_inc;
  logic [AW-1:0] slot;

  // Pattern store address for the current row
  always_comb begin
    slot = '0;
    if (part_now == PART_ROTATE) begin
      slot = AW'(frame_now) + AW'(1);
    end
    rd_addr = AW'(slot * AW'(ROWS)) + AW'(row_position);
  end

  // Display info for the current row
  always_comb begin
    info.row_drive   = (int'(row_position) < 8) ? (TOP_ROW_BIT >> row_position) : 8'd0;
    info.show_part   = part_now;
    info.frame_shown = (part_now == PART_ROTATE) ? 2'(frame_now) : 2'd0;
  end

  // Refresh limit of the current part, zero acts as one
  always_comb begin
    unique case (part_now)
      PART_STATIC:    limit_raw = cfg.static_refreshes;
      PART_FLASH_ON:  limit_raw = cfg.flash_on_refreshes;
      PART_FLASH_OFF: limit_raw = cfg.flash_off_refreshes;
      default:        limit_raw = cfg.rotate_refreshes;
    endcase
    limit = (limit_raw == 16'd0) ? 16'd1 : limit_raw;
  end

  // Next state after one tick
  always_comb begin
    row_position_next  = row_position;
    refresh_count_next = refresh_count;
    part_now_next      = part_now;
    frame_now_next     = frame_now;
    refresh_inc        = refresh_count + 16'd1;
    if (row_position != LAST_ROW) begin
      row_position_next = row_position + RW'(1);
    end else begin
      row_position_next  = '0;
      refresh_count_next = refresh_inc;
      if (refresh_inc >= limit || refresh_inc == 16'd0) begin
        // end of part
        refresh_count_next = 16'd0;
        priority if (part_now == PART_STATIC || part_now == PART_FLASH_ON) begin
          part_now_next = part_now + 2'd1;
        end else if (part_now == PART_FLASH_OFF) begin
          part_now_next  = PART_ROTATE;
          frame_now_next = cfg.play_ascending ? '0 : LAST_FRAME;
        end else if (cfg.play_ascending) begin
          if (frame_now >= LAST_FRAME) begin
            part_now_next  = PART_STATIC;
            frame_now_next = '0;
          end else begin
            frame_now_next = frame_now + FW'(1);
          end
        end else begin
          if (frame_now == '0 || frame_now > LAST_FRAME) begin
            part_now_next  = PART_STATIC;
            frame_now_next = '0;
          end else begin
            frame_now_next = frame_now - FW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_position  <= '0;
      refresh_count <= 16'd0;
      part_now      <= PART_STATIC;
      frame_now     <= '0;
    end else if (advance) begin
      row_position  <= row_position_next;
      refresh_count <= refresh_count_next;
      part_now      <= part_now_next;
      frame_now     <= frame_now_next;
    end
  end

endmodule

`default_nettype wire

// ----- design/blms_store.sv -----
// Pattern store: one red/green word per row per image, reads as all-off until written.
`default_nettype none

module blms_store #(
  parameter int ROWS   = 8,
  parameter int FRAMES = 4,
  parameter int DEPTH  = 40,
  parameter int AW     = 6
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          wr_en,
  input  wire logic [2:0]    frame_index,
  input  wire logic [2:0]    row_index,
  input  wire logic [7:0]    red_bits,
  input  wire logic [7:0]    green_bits,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic [15:0]        rd_word
);
  import blms_pkg::*;

  logic [15:0]      mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [15:0]      rd_data;
  logic             rd_vld;
  logic             wr_hit;
  logic [AW-1:0]    wr_addr;

  // Out-of-range targets are dropped
  assign wr_hit  = wr_en && (int'(frame_index) <= FRAMES) && (int'(row_index) < ROWS);
  assign wr_addr = AW'(int'(frame_index) * ROWS + int'(row_index));

  always_ff @(posedge clk) begin
    if (wr_hit) begin
      mem[wr_addr] <= {green_bits, red_bits};
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // Per-entry written flags
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_hit) begin
        vld[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld <= vld[rd_addr];
      end
    end
  end

  assign rd_word = rd_vld ? rd_data : WORD_OFF;

endmodule

`default_nettype wire

// ----- design/bicolor_led_matrix_scanner.sv -----
// Top level of the bicolor LED matrix row scanner.
//
//   channel | direction | handshake               | payload
//   --------+-----------+-------------------------+---------------------------------------
//   in      | input     | in_valid / in_stall     | req_type frame_index row_index
//           |           |                         | red_bits green_bits
//   out     | output    | out_valid / out_stall   | row_drive red_columns green_columns
//           |           |                         | show_part frame_shown
//   apb     | input     | psel penable pwrite     | paddr pwdata prdata pready
//
// One beat is taken per cycle while in_stall is low. A tick beat's result passes
// through the registered pattern store read and then the output register.
// Write beats give no result. in_stall rises only when both the read stage and the
// output register hold results and out_stall is high.
// Reset is synchronous; the pattern store reads as all-off through per-entry written
// flags, so no clearing pass is needed and beats are taken right after reset.
`default_nettype none

module bicolor_led_matrix_scanner #(
  parameter int ROWS   = 8,
  parameter int FRAMES = 4
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        req_type,
  input  wire logic [2:0]  frame_index,
  input  wire logic [2:0]  row_index,
  input  wire logic [7:0]  red_bits,
  input  wire logic [7:0]  green_bits,
  // output channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [7:0]       row_drive,
  output logic [7:0]       red_columns,
  output logic [7:0]       green_columns,
  output logic [1:0]       show_part,
  output logic [1:0]       frame_shown,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import blms_pkg::*;

  localparam int DEPTH = (FRAMES + 1) * ROWS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(ROWS);
  localparam int FW    = (FRAMES > 1) ? $clog2(FRAMES) : 1;

  cfg_t          cfg;
  tick_info_t    cur_info;
  tick_info_t    s1_info;
  logic [AW-1:0] rd_addr;
  logic [15:0]   rd_word;
  logic          in_fire, tick, wr;
  logic          s1_valid, s1_move, s2_ready;

  blms_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Handshake and stage flow
  assign s2_ready = !out_valid || !out_stall;
  assign s1_move  = s1_valid && s2_ready;
  assign in_stall = s1_valid && !s2_ready;
  assign in_fire  = in_valid && !in_stall;
  assign tick     = in_fire && (req_type == REQ_TICK);
  assign wr       = in_fire && (req_type == REQ_WRITE);

  blms_seq #(
    .ROWS   (ROWS),
    .FRAMES (FRAMES),
    .RW     (RW),
    .FW     (FW),
    .AW     (AW)
  ) u_seq (
    .clk     (clk),
    .rst     (rst),
    .advance (tick),
    .cfg     (cfg),
    .rd_addr (rd_addr),
    .info    (cur_info)
  );

  blms_store #(
    .ROWS   (ROWS),
    .FRAMES (FRAMES),
    .DEPTH  (DEPTH),
    .AW     (AW)
  ) u_store (
    .clk         (clk),
    .rst         (rst),
    .wr_en       (wr),
    .frame_index (frame_index),
    .row_index   (row_index),
    .red_bits    (red_bits),
    .green_bits  (green_bits),
    .rd_en       (tick),
    .rd_addr     (rd_addr),
    .rd_word     (rd_word)
  );

  // Read stage: info travels alongside the store read
  always_ff @(posedge clk) begin
    if (tick) begin
      s1_info <= cur_info;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (tick) begin
      s1_valid <= 1'b1;
    end else if (s1_move) begin
      s1_valid <= 1'b0;
    end
  end

  // Output register; flash-off part shows blank
  always_ff @(posedge clk) begin
    if (s1_move) begin
      row_drive   <= s1_info.row_drive;
      show_part   <= s1_info.show_part;
      frame_shown <= s1_info.frame_shown;
      if (s1_info.show_part == PART_FLASH_OFF) begin
        red_columns   <= ALL_OFF;
        green_columns <= ALL_OFF;
      end else begin
        red_columns   <= rd_word[7:0];
        green_columns <= rd_word[15:8];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

// ----- bench/bicolor_led_matrix_scanner_test.sv -----
// Self-checking testbench for the bicolor LED matrix scanner: directed and random beats.
`default_nettype none

module bicolor_led_matrix_scanner_test;
  import blms_pkg::*;

  localparam int NUM_ROWS     = 8;
  localparam int NUM_FRAMES   = 4;
  localparam int STORE_DEPTH  = (NUM_FRAMES + 1) * NUM_ROWS;
  localparam int DRAIN_CYCLES = 8;
  localparam int LONG_HOLD    = 60;
  localparam int CYCLE_LIMIT  = 500000;

  // one scan line as it leaves the block
  typedef struct packed {
    logic [7:0] row_drive;
    logic [7:0] red;
    logic [7:0] green;
    logic [1:0] part;
    logic [1:0] frame;
  } scan_line_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        req_type = REQ_TICK;
  logic [2:0]  frame_index = '0;
  logic [2:0]  row_index = '0;
  logic [7:0]  red_bits = '0;
  logic [7:0]  green_bits = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  row_drive;
  logic [7:0]  red_columns;
  logic [7:0]  green_columns;
  logic [1:0]  show_part;
  logic [1:0]  frame_shown;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  bicolor_led_matrix_scanner #(
    .ROWS   (NUM_ROWS),
    .FRAMES (NUM_FRAMES)
  ) uut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .req_type      (req_type),
    .frame_index   (frame_index),
    .row_index     (row_index),
    .red_bits      (red_bits),
    .green_bits    (green_bits),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .row_drive     (row_drive),
    .red_columns   (red_columns),
    .green_columns (green_columns),
    .show_part     (show_part),
    .frame_shown   (frame_shown),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #5 clk = ~clk;

  // Shadow of the scanner: registers, sequencer state and pattern store
  cfg_t        shadow_cfg = '{STATIC_RESET, FLASH_ON_RESET, FLASH_OFF_RESET,
                              ROTATE_RESET, FORWARD_RESET};
  int unsigned scan_row = 0;
  logic [15:0] scan_refreshes = '0;
  logic [1:0]  scan_part = PART_STATIC;
  int unsigned scan_frame = 0;
  logic [15:0] pattern_mem [0:STORE_DEPTH-1];

  scan_line_t  expected_lines [$];
  int          mismatches = 0;
  int          cycle_count = 0;

  // receiver control: quiet turns random stalls off, bumping hold_req asks a long hold
  bit          stall_quiet = 1'b0;
  int          hold_req = 0;
  int          hold_seen = 0;
  int          hold_left = 0;
  int          run_left = 0;

  // refresh count of the current part; zero counts as one
  function automatic logic [15:0] part_length();
    logic [15:0] n;
    case (scan_part)
      PART_STATIC:    n = shadow_cfg.static_refreshes;
      PART_FLASH_ON:  n = shadow_cfg.flash_on_refreshes;
      PART_FLASH_OFF: n = shadow_cfg.flash_off_refreshes;
      default:        n = shadow_cfg.rotate_refreshes;
    endcase
    return (n == '0) ? 16'd1 : n;
  endfunction

  // move to the next part or rotation frame
  function automatic void next_part();
    scan_refreshes = '0;
    case (scan_part)
      PART_STATIC:   scan_part = PART_FLASH_ON;
      PART_FLASH_ON: scan_part = PART_FLASH_OFF;
      PART_FLASH_OFF: begin
        scan_part  = PART_ROTATE;
        scan_frame = shadow_cfg.play_ascending ? 0 : NUM_FRAMES - 1;
      end
      default: begin
        if (shadow_cfg.play_ascending) begin
          if (scan_frame >= NUM_FRAMES - 1) begin
            scan_part  = PART_STATIC;
            scan_frame = 0;
          end else begin
            scan_frame++;
          end
        end else if (scan_frame == 0 || scan_frame > NUM_FRAMES - 1) begin
          scan_part  = PART_STATIC;
          scan_frame = 0;
        end else begin
          scan_frame--;
        end
      end
    endcase
  endfunction

  // scan line for one tick, then advance row and refresh counters
  function automatic void predict_scan_line();
    scan_line_t  line;
    int unsigned slot;
    logic [15:0] word;
    if (scan_row >= NUM_ROWS) scan_row = 0;
    if (scan_part == PART_FLASH_OFF) begin
      line.red   = ALL_OFF;
      line.green = ALL_OFF;
    end else begin
      slot = (scan_part == PART_ROTATE && scan_frame < NUM_FRAMES) ? scan_frame + 1 : 0;
      word = pattern_mem[slot * NUM_ROWS + scan_row];
      line.red   = word[7:0];
      line.green = word[15:8];
    end
    line.row_drive = (scan_row < 8) ? (TOP_ROW_BIT >> scan_row) : 8'h00;
    line.part      = scan_part;
    line.frame     = (scan_part == PART_ROTATE) ? 2'(scan_frame) : 2'd0;
    expected_lines.push_back(line);

    scan_row++;
    if (scan_row >= NUM_ROWS) begin
      scan_row = 0;
      scan_refreshes = scan_refreshes + 16'd1;
      if (scan_refreshes >= part_length() || scan_refreshes == '0) next_part();
    end
  endfunction

  // pattern write; targets past the last frame are dropped
  function automatic void store_pattern_row(input logic [2:0] fi, input logic [2:0] ri,
                                            input logic [7:0] red, input logic [7:0] green);
    if (fi <= NUM_FRAMES && ri < NUM_ROWS) pattern_mem[fi * NUM_ROWS + ri] = {green, red};
  endfunction

  // Offer one beat and hold it until accepted
  task automatic send_beat(input logic kind, input logic [2:0] fi, input logic [2:0] ri,
                           input logic [7:0] red, input logic [7:0] green);
    in_valid    <= 1'b1;
    req_type    <= kind;
    frame_index <= fi;
    row_index   <= ri;
    red_bits    <= red;
    green_bits  <= green;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (kind == REQ_WRITE) store_pattern_row(fi, ri, red, green);
    else predict_scan_line();
  endtask

  // sender gap: mostly none, sometimes short, rarely long
  task automatic sender_gap();
    int r;
    int n;
    r = $urandom_range(0, 99);
    n = (r < 65) ? 0 : (r < 93) ? $urandom_range(1, 3) : $urandom_range(6, 24);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // random beat: mostly ticks, some pattern writes, a few to dead frame slots
  task automatic random_beat(input bit with_gaps);
    logic       kind;
    logic [2:0] fi;
    kind = ($urandom_range(0, 99) < 15) ? REQ_WRITE : REQ_TICK;
    fi   = ($urandom_range(0, 99) < 85) ? 3'($urandom_range(0, NUM_FRAMES))
                                        : 3'($urandom_range(NUM_FRAMES + 1, 7));
    send_beat(kind, fi, 3'($urandom), 8'($urandom), 8'($urandom));
    if (with_gaps) sender_gap();
  endtask

  // wait for every scan line, then let write beats in flight settle
  task automatic drain_scanner();
    in_valid <= 1'b0;
    while (expected_lines.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write: setup then access; select is released by load_config
  task automatic write_register(input logic [2:0] idx, input logic [15:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {16'h0000, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (idx)
      REG_STATIC_REFRESHES:    shadow_cfg.static_refreshes    = value;
      REG_FLASH_ON_REFRESHES:  shadow_cfg.flash_on_refreshes  = value;
      REG_FLASH_OFF_REFRESHES: shadow_cfg.flash_off_refreshes = value;
      REG_ROTATE_REFRESHES:    shadow_cfg.rotate_refreshes    = value;
      REG_PLAY_ASCENDING:      shadow_cfg.play_ascending      = value[0];
      default: ;
    endcase
  endtask

  task automatic load_config(input logic [15:0] stat, input logic [15:0] fon,
                             input logic [15:0] foff, input logic [15:0] rot,
                             input logic fwd);
    write_register(REG_STATIC_REFRESHES, stat);
    write_register(REG_FLASH_ON_REFRESHES, fon);
    write_register(REG_FLASH_OFF_REFRESHES, foff);
    write_register(REG_ROTATE_REFRESHES, rot);
    write_register(REG_PLAY_ASCENDING, {15'd0, fwd});
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // refresh count: mostly short, with zero and full scale now and then
  function automatic logic [15:0] pick_refreshes();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom_range(1, 3));
  endfunction

  // Fresh block: unwritten store shows every LED off
  task automatic test_reset_image();
    repeat (8) send_beat(REQ_TICK, 3'd0, 3'd0, 8'h00, 8'h00);
  endtask

  // Extreme words, first and last slots, and writes past the last frame
  task automatic test_pattern_writes();
    send_beat(REQ_WRITE, 3'd0, 3'd0, 8'h00, 8'hFF);
    send_beat(REQ_WRITE, 3'd0, 3'd7, 8'hFF, 8'h00);
    send_beat(REQ_WRITE, 3'd0, 3'd3, 8'h55, 8'hAA);
    send_beat(REQ_WRITE, 3'd0, 3'd4, 8'hAA, 8'h55);
    send_beat(REQ_WRITE, 3'd1, 3'd0, 8'hA5, 8'h5A);
    send_beat(REQ_WRITE, 3'd4, 3'd7, 8'h00, 8'h00);
    send_beat(REQ_WRITE, 3'd5, 3'd1, 8'h00, 8'h00);
    send_beat(REQ_WRITE, 3'd6, 3'd2, 8'h0F, 8'hF0);
    send_beat(REQ_WRITE, 3'd7, 3'd7, 8'h00, 8'h00);
  endtask

  // Static count lowered to one mid-part, no higher than the refreshes already shown
  task automatic test_lowered_mid_part();
    drain_scanner();
    load_config(16'd1, shadow_cfg.flash_on_refreshes, shadow_cfg.flash_off_refreshes,
                shadow_cfg.rotate_refreshes, shadow_cfg.play_ascending);
    repeat (10) send_beat(REQ_TICK, 3'd0, 3'd0, 8'h00, 8'h00);
  endtask

  // Random phases, each with its own register set; every fourth runs with no idling
  task automatic test_random_show(input int phases, input int beats);
    bit steady;
    for (int p = 0; p < phases; p++) begin
      drain_scanner();
      steady = (p % 4 == 3);
      stall_quiet = steady;
      if (p == 0) load_config(16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
      else if (p == 1) load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
      else load_config(pick_refreshes(), pick_refreshes(), pick_refreshes(),
                       pick_refreshes(), 1'($urandom));
      repeat (beats) random_beat(!steady);
    end
    stall_quiet = 1'b0;
  endtask

  // Receiver holds off while ticks keep coming, so the input stalls
  task automatic test_backpressure();
    drain_scanner();
    load_config(16'd1, 16'd1, 16'd1, 16'd2, 1'b1);
    hold_req++;
    repeat (40) send_beat(REQ_TICK, 3'($urandom), 3'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // Sender pauses until every scan line is out, then resumes
  task automatic test_drain_pause();
    repeat (30) random_beat(1'b1);
    drain_scanner();
    repeat (30) random_beat(1'b1);
  endtask

  // Receiver stall pattern and long hold
  always @(posedge clk) begin
    int r;
    if (rst) begin
      out_stall <= 1'b0;
      hold_seen = hold_req;
    end else begin
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (stall_quiet) begin
        out_stall <= 1'b0;
        run_left = 0;
      end else if (run_left > 0) begin
        run_left--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 65) begin
          out_stall <= 1'b0;
          run_left = $urandom_range(1, 6);
        end else begin
          out_stall <= 1'b1;
          run_left = (r < 93) ? $urandom_range(0, 2) : $urandom_range(5, 25);
        end
      end
    end
  end

  // Result check against the oldest expected scan line
  always @(posedge clk) begin
    scan_line_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_lines.size() == 0) begin
        $error("scan line with none expected: row_drive %h", row_drive);
        mismatches++;
      end else begin
        want = expected_lines.pop_front();
        if (row_drive !== want.row_drive) begin
          $error("row_drive: expected %h, got %h", want.row_drive, row_drive);
          mismatches++;
        end
        if (red_columns !== want.red) begin
          $error("red_columns: expected %h, got %h", want.red, red_columns);
          mismatches++;
        end
        if (green_columns !== want.green) begin
          $error("green_columns: expected %h, got %h", want.green, green_columns);
          mismatches++;
        end
        if (show_part !== want.part) begin
          $error("show_part: expected %0d, got %0d", want.part, show_part);
          mismatches++;
        end
        if (frame_shown !== want.frame) begin
          $error("frame_shown: expected %0d, got %0d", want.frame, frame_shown);
          mismatches++;
        end
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < STORE_DEPTH; i++) pattern_mem[i] = WORD_OFF;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    test_reset_image();
    test_pattern_writes();
    test_lowered_mid_part();
    test_random_show(12, 110);
    test_backpressure();
    test_drain_pause();

    drain_scanner();
    if (mismatches == 0 && expected_lines.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
